[src/rtch_pkg.sv]
// ----------------------------------------------------------------------------
// rtch_pkg
// Types and constants shared by the ray/triangle closest-hit block.
// ----------------------------------------------------------------------------
package rtch_pkg;

  localparam int FRAC_BITS = 16;
  localparam int OBJ_BITS  = 10;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_ORG_X = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORG_Y = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORG_Z = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIR_X = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIR_Y = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIR_Z = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_EPS   = 3'd6;

  localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic signed [31:0] v0_x;
    logic signed [31:0] v0_y;
    logic signed [31:0] v0_z;
    logic signed [31:0] v1_x;
    logic signed [31:0] v1_y;
    logic signed [31:0] v1_z;
    logic signed [31:0] v2_x;
    logic signed [31:0] v2_y;
    logic signed [31:0] v2_z;
    logic [OBJ_BITS-1:0] object_id;
    logic                last_in_ray;
  } in_item_t;

  typedef struct packed {
    logic                hit;
    logic [30:0]         hit_distance;
    logic                nearest_found;
    logic [OBJ_BITS-1:0] nearest_object;
    logic [30:0]         nearest_distance;
    logic                ray_done;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EDGE, ST_MUL, ST_CHECK, ST_DIV, ST_DONE, ST_OUT
  } state_e;

  // divider control/status
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quot;
  } div_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (x < -66'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return x[31:0];
    end
  endfunction

endpackage

[src/rtch_div.sv]
// ----------------------------------------------------------------------------
// rtch_div
// Radix-2 restoring divider, one quotient bit per cycle (64-bit / 32-bit).
// ----------------------------------------------------------------------------
module rtch_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rtch_pkg::div_ctl_t ctl_i,
  input  logic [63:0]      num_i,
  input  logic [31:0]      den_i,
  output rtch_pkg::div_sts_t sts_o
);
  logic [63:0] quot_q, quot_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;
  logic [33:0] diff;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[31:0], quot_q[63]};
    diff   = {1'b0, trial} - {2'b00, den_q};
    if (ctl_i.start) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[33]) begin
        rem_d = diff[32:0];
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign sts_o.quot = quot_q;
endmodule

[src/ray_triangle_closest_hit.sv]
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit
// Moller-Trumbore test of a stream of triangles against one configured ray,
// tracking the nearest hit per ray.
// ----------------------------------------------------------------------------
// One triangle item is taken at a time. After edge setup, the 24 products of h,
// q, a, du, dv and dt go one per cycle through a single 32x32 multiplier
// with a registered product, then come the range tests, and for candidate
// hits a bit-serial divider. The output register holds the result item until
// taken; the next triangle is accepted only after the result has left.
module ray_triangle_closest_hit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rtch_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rtch_pkg::out_item_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic [rtch_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i
);
  logic signed [31:0] org_q [3];
  logic signed [31:0] dir_q [3];
  logic [15:0]        eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0; org_q[1] <= '0; org_q[2] <= '0;
      dir_q[0] <= '0; dir_q[1] <= '0;
      dir_q[2] <= 32'sd65536;
      eps_q    <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rtch_pkg::REG_ORG_X: org_q[0] <= cfg_data_i;
        rtch_pkg::REG_ORG_Y: org_q[1] <= cfg_data_i;
        rtch_pkg::REG_ORG_Z: org_q[2] <= cfg_data_i;
        rtch_pkg::REG_DIR_X: dir_q[0] <= cfg_data_i;
        rtch_pkg::REG_DIR_Y: dir_q[1] <= cfg_data_i;
        rtch_pkg::REG_DIR_Z: dir_q[2] <= cfg_data_i;
        rtch_pkg::REG_EPS:   eps_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  rtch_pkg::state_e state_q, state_d;
  rtch_pkg::in_item_t item_q;
  logic signed [31:0] e1_q [3], e2_q [3], s_q [3], h_q [3], q_q [3];
  logic signed [31:0] a_q, du_q, dv_q, dt_q;
  logic signed [65:0] acc_q, acc_d;
  logic signed [63:0] prod_q;
  logic               prod_vld_q;
  logic [4:0]         step_q, step_d;
  logic [30:0]        best_dist_q;
  logic [rtch_pkg::OBJ_BITS-1:0] best_obj_q;
  logic               best_vld_q;
  rtch_pkg::out_item_t out_q;
  logic               out_vld_q;

  // multiplier operand select, one product per step
  logic signed [31:0] op_a, op_b;
  logic               sub_op;
  always_comb begin
    op_a = '0; op_b = '0; sub_op = 1'b0;
    case (step_q)
      5'd0:  begin op_a = dir_q[1]; op_b = e2_q[2]; end
      5'd1:  begin op_a = dir_q[2]; op_b = e2_q[1]; sub_op = 1'b1; end
      5'd2:  begin op_a = dir_q[2]; op_b = e2_q[0]; end
      5'd3:  begin op_a = dir_q[0]; op_b = e2_q[2]; sub_op = 1'b1; end
      5'd4:  begin op_a = dir_q[0]; op_b = e2_q[1]; end
      5'd5:  begin op_a = dir_q[1]; op_b = e2_q[0]; sub_op = 1'b1; end
      5'd6:  begin op_a = s_q[1]; op_b = e1_q[2]; end
      5'd7:  begin op_a = s_q[2]; op_b = e1_q[1]; sub_op = 1'b1; end
      5'd8:  begin op_a = s_q[2]; op_b = e1_q[0]; end
      5'd9:  begin op_a = s_q[0]; op_b = e1_q[2]; sub_op = 1'b1; end
      5'd10: begin op_a = s_q[0]; op_b = e1_q[1]; end
      5'd11: begin op_a = s_q[1]; op_b = e1_q[0]; sub_op = 1'b1; end
      5'd12: begin op_a = e1_q[0]; op_b = h_q[0]; end
      5'd13: begin op_a = e1_q[1]; op_b = h_q[1]; end
      5'd14: begin op_a = e1_q[2]; op_b = h_q[2]; end
      5'd15: begin op_a = s_q[0]; op_b = h_q[0]; end
      5'd16: begin op_a = s_q[1]; op_b = h_q[1]; end
      5'd17: begin op_a = s_q[2]; op_b = h_q[2]; end
      5'd18: begin op_a = dir_q[0]; op_b = q_q[0]; end
      5'd19: begin op_a = dir_q[1]; op_b = q_q[1]; end
      5'd20: begin op_a = dir_q[2]; op_b = q_q[2]; end
      5'd21: begin op_a = e2_q[0]; op_b = q_q[0]; end
      5'd22: begin op_a = e2_q[1]; op_b = q_q[1]; end
      5'd23: begin op_a = e2_q[2]; op_b = q_q[2]; end
      default: ;
    endcase
  end

  logic [4:0] pstep_q;
  logic       psub_q;
  logic signed [47:0] fl;
  logic signed [65:0] acc_sum;
  logic signed [31:0] acc_sat;
  assign fl = 48'(prod_q >>> rtch_pkg::FRAC_BITS);
  assign acc_sum = psub_q ? acc_q - 66'(fl) : acc_q + 66'(fl);
  assign acc_sat = rtch_pkg::sat32(acc_sum);

  always_comb begin
    acc_d = acc_sum;
    case (pstep_q)
      5'd0, 5'd2, 5'd4, 5'd6, 5'd8, 5'd10, 5'd12, 5'd15, 5'd18, 5'd21: begin
        acc_d = 66'(fl);
      end
      default: ;
    endcase
  end

  // edge setup
  function automatic logic signed [31:0] dsat(input logic signed [31:0] x,
                                              input logic signed [31:0] y);
    return rtch_pkg::sat32(66'(x) - 66'(y));
  endfunction

  // normalized values and checks
  logic               neg;
  logic               pass;
  assign neg = a_q < 0;
  logic [32:0] an_abs;
  assign an_abs = neg ? 33'(-34'(a_q)) : 33'(a_q);
  logic signed [33:0] an_x, dun_x, dvn_x, dtn_x;
  assign an_x  = neg ? -34'(a_q)  : 34'(a_q);
  assign dun_x = neg ? -34'(du_q) : 34'(du_q);
  assign dvn_x = neg ? -34'(dv_q) : 34'(dv_q);
  assign dtn_x = neg ? -34'(dt_q) : 34'(dt_q);
  always_comb begin
    pass = 1'b1;
    if (an_x == 0 || an_x < 34'(eps_q)) pass = 1'b0;
    if (dun_x < 0 || dun_x > an_x) pass = 1'b0;
    if (dvn_x < 0 || (dun_x + dvn_x) > an_x) pass = 1'b0;
    if (dtn_x <= 0) pass = 1'b0;
  end

  rtch_pkg::div_ctl_t div_ctl;
  rtch_pkg::div_sts_t div_sts;
  rtch_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(div_ctl),
    .num_i({dtn_x[31:0], 32'd0} >> (32 - rtch_pkg::FRAC_BITS)),
    .den_i(an_abs[31:0]), .sts_o(div_sts)
  );

  logic [30:0] t_sat;
  logic        t_hit;
  assign t_sat = (div_sts.quot > 64'(rtch_pkg::DIST_MAX)) ? rtch_pkg::DIST_MAX
                                                          : div_sts.quot[30:0];
  assign t_hit = t_sat > 31'(eps_q);

  logic        fin;
  logic        fin_hit;
  logic [30:0] fin_dist;
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    div_ctl.start = 1'b0;
    fin = 1'b0; fin_hit = 1'b0; fin_dist = '0;
    case (state_q)
      rtch_pkg::ST_IDLE: begin
        if (in_valid_i && !out_vld_q) state_d = rtch_pkg::ST_EDGE;
      end
      rtch_pkg::ST_EDGE: begin
        step_d = '0;
        state_d = rtch_pkg::ST_MUL;
      end
      rtch_pkg::ST_MUL: begin
        if (step_q != 5'd24) step_d = step_q + 5'd1;
        if (prod_vld_q && pstep_q == 5'd23) state_d = rtch_pkg::ST_CHECK;
      end
      rtch_pkg::ST_CHECK: begin
        if (pass) begin
          div_ctl.start = 1'b1;
          state_d = rtch_pkg::ST_DIV;
        end else begin
          fin = 1'b1;
          state_d = rtch_pkg::ST_OUT;
        end
      end
      rtch_pkg::ST_DIV: begin
        if (div_sts.done) begin
          fin = 1'b1;
          fin_hit = t_hit;
          fin_dist = t_hit ? t_sat : '0;
          state_d = rtch_pkg::ST_OUT;
        end
      end
      rtch_pkg::ST_OUT: begin
        if (!out_vld_q) state_d = rtch_pkg::ST_IDLE;
      end
      default: state_d = rtch_pkg::ST_IDLE;
    endcase
  end

  logic take;
  assign take = state_q == rtch_pkg::ST_IDLE && in_valid_i && !out_vld_q;
  assign in_stall_o = !(state_q == rtch_pkg::ST_IDLE && !out_vld_q);

  logic        upd;
  logic [30:0] nb_dist;
  logic [rtch_pkg::OBJ_BITS-1:0] nb_obj;
  logic        nb_vld;
  always_comb begin
    upd = fin_hit && (!best_vld_q || fin_dist < best_dist_q);
    nb_dist = upd ? fin_dist : best_dist_q;
    nb_obj  = upd ? item_q.object_id : best_obj_q;
    nb_vld  = best_vld_q || upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rtch_pkg::ST_IDLE;
      step_q <= '0;
      prod_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      best_vld_q <= 1'b0;
      best_dist_q <= rtch_pkg::DIST_MAX;
      best_obj_q <= '0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
      prod_vld_q <= state_q == rtch_pkg::ST_MUL && step_q != 5'd24;
      if (out_vld_q && !out_stall_i) out_vld_q <= 1'b0;
      if (fin) begin
        out_vld_q <= 1'b1;
        if (item_q.last_in_ray) begin
          best_vld_q <= 1'b0;
          best_dist_q <= rtch_pkg::DIST_MAX;
          best_obj_q <= '0;
        end else begin
          best_vld_q <= nb_vld;
          best_dist_q <= nb_dist;
          best_obj_q <= nb_obj;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) item_q <= in_data_i;
    if (state_q == rtch_pkg::ST_EDGE) begin
      e1_q[0] <= dsat(item_q.v1_x, item_q.v0_x);
      e1_q[1] <= dsat(item_q.v1_y, item_q.v0_y);
      e1_q[2] <= dsat(item_q.v1_z, item_q.v0_z);
      e2_q[0] <= dsat(item_q.v2_x, item_q.v0_x);
      e2_q[1] <= dsat(item_q.v2_y, item_q.v0_y);
      e2_q[2] <= dsat(item_q.v2_z, item_q.v0_z);
      s_q[0]  <= dsat(org_q[0], item_q.v0_x);
      s_q[1]  <= dsat(org_q[1], item_q.v0_y);
      s_q[2]  <= dsat(org_q[2], item_q.v0_z);
    end
    prod_q  <= op_a * op_b;
    pstep_q <= step_q;
    psub_q  <= sub_op;
    if (prod_vld_q) begin
      acc_q <= acc_d;
      case (pstep_q)
        5'd1:  h_q[0] <= acc_sat;
        5'd3:  h_q[1] <= acc_sat;
        5'd5:  h_q[2] <= acc_sat;
        5'd7:  q_q[0] <= acc_sat;
        5'd9:  q_q[1] <= acc_sat;
        5'd11: q_q[2] <= acc_sat;
        5'd14: a_q  <= acc_sat;
        5'd17: du_q <= acc_sat;
        5'd20: dv_q <= acc_sat;
        5'd23: dt_q <= acc_sat;
        default: ;
      endcase
    end
    if (fin) begin
      out_q.hit <= fin_hit;
      out_q.hit_distance <= fin_dist;
      out_q.nearest_found <= nb_vld;
      out_q.nearest_object <= nb_vld ? nb_obj : '0;
      out_q.nearest_distance <= nb_vld ? nb_dist : '0;
      out_q.ray_done <= item_q.last_in_ray;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
endmodule
